// ===== sv/json_string_escaper_macros.svh =====
// Assertion macros for the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jse_pkg.sv =====
// Types, character constants and escape function for the JSON string escaper.
package jse_pkg;

    localparam int unsigned MaxSeq   = 7;
    localparam int unsigned MaxEsc   = 6;
    localparam int unsigned SeqLenW  = 3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_LOW = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } jse_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } jse_out_t;

    typedef logic [MaxSeq-1:0][7:0] jse_seq_t;

    // Escape of one raw byte: b[0] goes out first.
    typedef struct packed {
        logic [MaxEsc-1:0][7:0] b;
        logic [SeqLenW-1:0]     len;
    } jse_esc_t;

    // Encoded item handed to the sequence register.
    typedef struct packed {
        jse_seq_t           bytes;
        logic [SeqLenW-1:0] len;
        logic               open_next;
    } jse_enc_t;

    // Head of the sequence register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } jse_head_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CHAR_ZERO + {4'h0, n};
        end else begin
            r = CHAR_A_LOW + {4'h0, n} - 8'd10;
        end
        return r;
    endfunction

    function automatic jse_esc_t escape_byte(input logic [7:0] c);
        jse_esc_t e;
        e = '0;
        case (c)
            CHAR_BSLASH: begin
                e.b[0] = CHAR_BSLASH; e.b[1] = CHAR_BSLASH; e.len = 3'd2;
            end
            CHAR_QUOTE: begin
                e.b[0] = CHAR_BSLASH; e.b[1] = CHAR_QUOTE; e.len = 3'd2;
            end
            CHAR_CR: begin
                e.b[0] = CHAR_BSLASH; e.b[1] = CHAR_R; e.len = 3'd2;
            end
            CHAR_LF: begin
                e.b[0] = CHAR_BSLASH; e.b[1] = CHAR_N; e.len = 3'd2;
            end
            CHAR_TAB: begin
                e.b[0] = CHAR_BSLASH; e.b[1] = CHAR_T; e.len = 3'd2;
            end
            default: begin
                if (c < CTRL_LIMIT) begin
                    e.b[0] = CHAR_BSLASH;
                    e.b[1] = CHAR_U;
                    e.b[2] = CHAR_ZERO;
                    e.b[3] = CHAR_ZERO;
                    e.b[4] = hex_digit(c[7:4]);
                    e.b[5] = hex_digit(c[3:0]);
                    e.len  = 3'd6;
                end else begin
                    e.b[0] = c;
                    e.len  = 3'd1;
                end
            end
        endcase
        return e;
    endfunction

endpackage

// ===== sv/jse_encode.sv =====
// Combinational encoder: one input item to its output byte sequence.
module jse_encode (
    input  jse_pkg::jse_in_t  item,
    input  logic              string_open,
    output jse_pkg::jse_enc_t enc
);

    jse_pkg::jse_esc_t esc;

    always_comb begin
        esc = jse_pkg::escape_byte(item.in_byte);
        enc = '0;
        if (item.kind == jse_pkg::KIND_END) begin
            // closing quote, both quotes for an empty string
            enc.bytes[0]  = jse_pkg::CHAR_QUOTE;
            enc.bytes[1]  = jse_pkg::CHAR_QUOTE;
            enc.len       = string_open ? 3'd1 : 3'd2;
            enc.open_next = 1'b0;
        end else if (!string_open) begin
            enc.bytes[0] = jse_pkg::CHAR_QUOTE;
            for (int k = 0; k < jse_pkg::MaxEsc; k++) begin
                enc.bytes[k+1] = esc.b[k];
            end
            enc.len       = esc.len + 3'd1;
            enc.open_next = 1'b1;
        end else begin
            for (int k = 0; k < jse_pkg::MaxEsc; k++) begin
                enc.bytes[k] = esc.b[k];
            end
            enc.len       = esc.len;
            enc.open_next = 1'b1;
        end
    end

endmodule

// ===== sv/jse_seq.sv =====
// Sequence register: holds the encoded bytes of one item and the string state.
module jse_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              pop,
    input  jse_pkg::jse_enc_t enc,
    output jse_pkg::jse_head_t head,
    output logic              string_open
);

    jse_pkg::jse_seq_t            seq_reg, seq_next;
    logic [jse_pkg::SeqLenW-1:0] cnt_reg, cnt_next;
    logic                         open_reg, open_next;

    always_comb begin
        seq_next  = seq_reg;
        cnt_next  = cnt_reg;
        open_next = open_reg;
        if (load) begin
            seq_next  = enc.bytes;
            cnt_next  = enc.len;
            open_next = enc.open_next;
        end else if (pop) begin
            for (int k = 0; k < jse_pkg::MaxSeq - 1; k++) begin
                seq_next[k] = seq_reg[k+1];
            end
            seq_next[jse_pkg::MaxSeq-1] = '0;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            open_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            open_reg <= open_next;
        end
        seq_reg <= seq_next;
    end

    assign head.valid  = (cnt_reg != 3'd0);
    assign head.data   = seq_reg[0];
    assign head.last   = (cnt_reg == 3'd1);
    assign string_open = open_reg;

endmodule

// ===== sv/json_string_escaper.sv =====
// JSON string escaper: top level with handshake control and output register.
//
// Turns a stream of raw string bytes into JSON string literal text, one
// output byte per transfer. The first byte of a string is preceded by an
// opening quote; backslash and quote become backslash pairs; CR, LF and TAB
// become \r, \n and \t; other bytes below 0x20 become \u00xx (lowercase hex);
// every other byte passes through. An end item (kind = 1) emits the closing
// quote, or two quotes for an empty string. m_payload.last marks the final
// byte produced by each input item. An accepted item is encoded at once
// into a sequence register of up to seven bytes, which drains one byte per
// cycle into the output register unless it is stalled. An item yields 1
// byte for a plain byte or a closing quote, 2 for a short escape, a plain
// byte opening a string or an empty string, 3 for a short escape opening
// a string, and 6 or 7 for \u00xx. Plain bytes stream at one item per
// cycle while the output is not stalled, a figure the output register's
// one-byte-per-cycle drain sets. A new item is taken at once while the
// sequence register is empty, or in the cycle its predecessor's final byte
// moves to the output register; while the output register is stalled on an
// earlier byte, that final byte cannot move and the input waits with it.
`include "json_string_escaper_macros.svh"

module json_string_escaper (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jse_pkg::jse_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output jse_pkg::jse_out_t m_payload
);

    jse_pkg::jse_enc_t  enc;
    jse_pkg::jse_head_t head;
    logic               string_open;
    logic               s_accept;
    logic               out_load;

    logic              m_valid_reg, m_valid_next;
    jse_pkg::jse_out_t m_payload_reg, m_payload_next;

    // Output register is free when empty or being emptied this cycle.
    assign out_load = head.valid && (!m_valid_reg || m_ready);

    // Take a new item once the sequence is empty or its final byte leaves now.
    assign s_ready  = !head.valid || (head.last && out_load);
    assign s_accept = s_valid && s_ready;

    jse_encode u_encode (
        .item        (s_payload),
        .string_open (string_open),
        .enc         (enc)
    );

    jse_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (s_accept),
        .pop         (out_load),
        .enc         (enc),
        .head        (head),
        .string_open (string_open)
    );

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_payload_next.out_byte = head.data;
            m_payload_next.last     = head.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Every item yields at least one byte, so the sequence is never empty after a load.
    `JSE_ASSERT_NEXT(a_load_fills, s_accept, head.valid, "sequence empty after item transfer")

    // A byte that is not last has successors queued, so the output stays valid.
    `JSE_ASSERT_NEXT(a_no_gap, m_valid && m_ready && !m_payload.last, m_valid, "gap inside an item's output")

    // String closes only on an end item.
    `JSE_ASSERT_IMPL(a_close_on_end, $fell(string_open), $past(s_accept && s_payload.kind == jse_pkg::KIND_END), "string closed without end item")

    // Input is never taken while undelivered bytes of the previous item wait.
    `JSE_ASSERT_IMPL(a_no_overrun, s_accept && head.valid, head.last && out_load, "item transfer over pending bytes")

endmodule
